// ===== hw/rtl/clook_pkg.sv =====
// clook_pkg: shared types and constants of the c-look request scheduler
// no dependencies; imported by clook_cell, clook_queue and the top level

package clook_pkg;

	localparam int QueueDepthDef = 32;
	localparam int TrackBitsDef  = 12;
	localparam int TagBitsDef    = 16;

	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_POP = 1'b1;

	localparam logic [1:0] ST_SERVED = 2'd0;
	localparam logic [1:0] ST_ADDED  = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	// broadcast from a queue to every cell of its chain
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/clook_disk_request_scheduler.sv =====
// clook_disk_request_scheduler: c-look scheduler over two sorted cell chains
// depends on clook_pkg and clook_queue
//
//   channel | direction | beat contents
//   --------+-----------+-------------------------------------
//   in      | in        | mode, track, tag, head_track
//   out     | out       | status, served_track, served_tag
//
// one beat in gives one beat out, in the next cycle from the result register
// an add or pop updates the whole chain in the cycle it is accepted: up to one beat per cycle while in_stall is low
// reset clears both fill counts and the result valid flag; no clearing pass
// in_stall is raised only while a result waits and out_stall holds it

module clook_disk_request_scheduler #(
	parameter int QUEUE_DEPTH = clook_pkg::QueueDepthDef,
	parameter int TRACK_BITS  = clook_pkg::TrackBitsDef,
	parameter int TAG_BITS    = clook_pkg::TagBitsDef
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [TRACK_BITS-1:0] track,
	input  logic [TAG_BITS-1:0]   tag,
	input  logic [TRACK_BITS-1:0] head_track,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [TRACK_BITS-1:0] served_track,
	output logic [TAG_BITS-1:0]   served_tag
);
	import clook_pkg::*;

	logic                  accept;
	logic                  to_upper;
	logic                  up_full, up_empty, lo_full, lo_empty;
	logic [TRACK_BITS-1:0] up_trk, lo_trk;
	logic [TAG_BITS-1:0]   up_tag, lo_tag;
	cell_ctl_t             up_ctl, lo_ctl;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [TRACK_BITS-1:0] served_track_q;
	logic [TAG_BITS-1:0]   served_tag_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign to_upper = (track >= head_track);

	always_comb begin
		up_ctl.ins = accept && (mode == MODE_ADD) && to_upper && !up_full;
		lo_ctl.ins = accept && (mode == MODE_ADD) && !to_upper && !lo_full;
		up_ctl.pop = accept && (mode == MODE_POP) && !up_empty;
		lo_ctl.pop = accept && (mode == MODE_POP) && up_empty && !lo_empty;
	end

	clook_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TRACK_BITS (TRACK_BITS),
		.TAG_BITS   (TAG_BITS)
	) u_upper (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (up_ctl),
		.new_trk  (track),
		.new_tag  (tag),
		.full     (up_full),
		.empty    (up_empty),
		.front_trk(up_trk),
		.front_tag(up_tag)
	);

	clook_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TRACK_BITS (TRACK_BITS),
		.TAG_BITS   (TAG_BITS)
	) u_lower (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lo_ctl),
		.new_trk  (track),
		.new_tag  (tag),
		.full     (lo_full),
		.empty    (lo_empty),
		.front_trk(lo_trk),
		.front_tag(lo_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (mode == MODE_ADD) begin
				status_q       <= (up_ctl.ins || lo_ctl.ins) ? ST_ADDED : ST_FULL;
				served_track_q <= '0;
				served_tag_q   <= '0;
			end else if (!up_empty) begin
				status_q       <= ST_SERVED;
				served_track_q <= up_trk;
				served_tag_q   <= up_tag;
			end else if (!lo_empty) begin
				status_q       <= ST_SERVED;
				served_track_q <= lo_trk;
				served_tag_q   <= lo_tag;
			end else begin
				status_q       <= ST_EMPTY;
				served_track_q <= '0;
				served_tag_q   <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign served_track = served_track_q;
	assign served_tag   = served_tag_q;

	a_accept_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted beat gave no result");

	a_one_pop_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(up_ctl.pop && lo_ctl.pop))
		else $error("both queues popped at once");

	a_zero_when_unserved: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_SERVED) |-> (served_track == '0 && served_tag == '0))
		else $error("served fields not zero");

endmodule

// ===== hw/rtl/clook_cell.sv =====
// clook_cell: one slot of a sorted request chain, holds a track and a tag
// depends on clook_pkg; instantiated in a row by clook_queue

module clook_cell #(
	parameter int TRACK_BITS = 12,
	parameter int TAG_BITS   = 16
) (
	input  logic                    clk,
	input  clook_pkg::cell_ctl_t    ctl,
	input  logic                    occupied,
	input  logic [TRACK_BITS-1:0]   new_trk,
	input  logic [TAG_BITS-1:0]     new_tag,
	input  logic                    prev_gt,
	input  logic [TRACK_BITS-1:0]   prev_trk,
	input  logic [TAG_BITS-1:0]     prev_tag,
	input  logic [TRACK_BITS-1:0]   next_trk,
	input  logic [TAG_BITS-1:0]     next_tag,
	output logic                    gt,
	output logic [TRACK_BITS-1:0]   trk_q,
	output logic [TAG_BITS-1:0]     tag_q
);
	import clook_pkg::*;

	// an empty slot counts as greater, so the new entry lands at the tail
	assign gt = !occupied || (trk_q > new_trk);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_gt) begin
				trk_q <= prev_trk;
				tag_q <= prev_tag;
			end else if (gt) begin
				trk_q <= new_trk;
				tag_q <= new_tag;
			end
		end else if (ctl.pop) begin
			trk_q <= next_trk;
			tag_q <= next_tag;
		end
	end

endmodule

// ===== hw/rtl/clook_queue.sv =====
// clook_queue: ascending track queue built as a shifting chain of cells
// depends on clook_pkg and clook_cell

module clook_queue #(
	parameter int QUEUE_DEPTH = clook_pkg::QueueDepthDef,
	parameter int TRACK_BITS  = clook_pkg::TrackBitsDef,
	parameter int TAG_BITS    = clook_pkg::TagBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  clook_pkg::cell_ctl_t   ctl,
	input  logic [TRACK_BITS-1:0]  new_trk,
	input  logic [TAG_BITS-1:0]    new_tag,
	output logic                   full,
	output logic                   empty,
	output logic [TRACK_BITS-1:0]  front_trk,
	output logic [TAG_BITS-1:0]    front_tag
);
	import clook_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]      count_q;
	logic [QUEUE_DEPTH-1:0] gt;
	logic [TRACK_BITS-1:0] trk [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]   tg  [QUEUE_DEPTH];

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign front_trk = trk[0];
	assign front_tag = tg[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			logic                  p_gt;
			logic [TRACK_BITS-1:0] p_trk;
			logic [TAG_BITS-1:0]   p_tag;
			logic [TRACK_BITS-1:0] n_trk;
			logic [TAG_BITS-1:0]   n_tag;

			if (i == 0) begin : g_first
				assign p_gt  = 1'b0;
				assign p_trk = new_trk;
				assign p_tag = new_tag;
			end else begin : g_mid
				assign p_gt  = gt[i-1];
				assign p_trk = trk[i-1];
				assign p_tag = tg[i-1];
			end

			// the tail slot only ever falls beyond the count on a pop
			if (i == QUEUE_DEPTH - 1) begin : g_last
				assign n_trk = trk[i];
				assign n_tag = tg[i];
			end else begin : g_inner
				assign n_trk = trk[i+1];
				assign n_tag = tg[i+1];
			end

			clook_cell #(
				.TRACK_BITS(TRACK_BITS),
				.TAG_BITS  (TAG_BITS)
			) u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.occupied(count_q > CNT_W'(i)),
				.new_trk (new_trk),
				.new_tag (new_tag),
				.prev_gt (p_gt),
				.prev_trk(p_trk),
				.prev_tag(p_tag),
				.next_trk(n_trk),
				.next_tag(n_tag),
				.gt      (gt[i]),
				.trk_q   (trk[i]),
				.tag_q   (tg[i])
			);
		end
	endgenerate

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_ins_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.ins && ctl.pop))
		else $error("insert and pop in one cycle");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |-> !full)
		else $error("insert into full queue");

	a_pop_grows_down: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not shrink the count");

endmodule
